@@ hdl/modbus_rtu_request_framer_defines.svh @@
// Assertion macros for the Modbus RTU request framer checker.
// Used by the bound checker only; no other dependencies.
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH

// Clocked assertion, masked while reset is high
`define MBRF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define MBRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mbrf_pkg.sv @@
// Shared types, codes and the CRC-16/MODBUS byte update for the request framer.
// No dependencies.
package mbrf_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_DATA   = 1'b1;

   localparam logic [7:0] FC_READ_COILS     = 8'd1;
   localparam logic [7:0] FC_READ_INPUTS    = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;

   typedef struct packed {
      logic        command;
      logic [7:0]  slave_address;
      logic [7:0]  function_code;
      logic [15:0] start_address;
      logic [15:0] quantity;
      logic [7:0]  data_len;
      logic [15:0] data_word;
      logic        final_word;
   } req_item_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ hdl/mbrf_if.sv @@
// Valid/ready channel interfaces for the request framer: request items in, frame bytes out.
// No dependencies.
interface mbrf_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  slave_address;
   logic [7:0]  function_code;
   logic [15:0] start_address;
   logic [15:0] quantity;
   logic [7:0]  data_len;
   logic [15:0] data_word;
   logic        final_word;

   modport source (
      output valid, command, slave_address, function_code, start_address,
             quantity, data_len, data_word, final_word,
      input  ready
   );
   modport sink (
      input  valid, command, slave_address, function_code, start_address,
             quantity, data_len, data_word, final_word,
      output ready
   );
endinterface

interface mbrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

@@ hdl/modbus_rtu_request_framer.sv @@
// Modbus RTU request framer: serializes request items into frame bytes with CRC-16/MODBUS.
// Depends on mbrf_pkg and the mbrf_req_if / mbrf_rsp_if interfaces.
//
// One frame byte leaves per cycle through a single output byte register while the
// receiver takes it; a stalled byte holds the block. A header yields 6 (unknown
// function), 7 (write multiple with data to follow), 8 (read) or 9 (write multiple with
// a zero byte count) bytes, a data word yields 2, or 4 when it is marked final, and a
// data word with no write frame open is dropped with no byte, even under a stall. The
// next item is taken in the cycle the last byte of the current one is loaded, so items
// run back to back. The CRC is updated by one byte per cycle alongside the output
// register when unstalled; a header's first byte goes via the item and output registers.
module modbus_rtu_request_framer (
   input logic      clock,
   input logic      reset,
   mbrf_req_if.sink   req,
   mbrf_rsp_if.source rsp
);

   mbrf_pkg::req_item_type item_ff, item_in, req_item;
   logic        busy_ff, busy_in;
   logic [3:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        wframe_ff, wframe_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_end_ff, rsp_end_in;

   logic        slot_free, step, accept, req_ready;
   logic        is_read, is_write;
   logic [15:0] crc_base;
   logic [7:0]  byte_val;
   logic        is_crc, last, frame_end, drop;

   assign req_item = '{
      command:       req.command,
      slave_address: req.slave_address,
      function_code: req.function_code,
      start_address: req.start_address,
      quantity:      req.quantity,
      data_len:      req.data_len,
      data_word:     req.data_word,
      final_word:    req.final_word
   };

   assign is_read = (item_ff.function_code == mbrf_pkg::FC_READ_COILS)
                 || (item_ff.function_code == mbrf_pkg::FC_READ_INPUTS)
                 || (item_ff.function_code == mbrf_pkg::FC_READ_HOLDING);
   assign is_write = (item_ff.function_code == mbrf_pkg::FC_WRITE_MULTIPLE);

   // a header always restarts the CRC on its first byte
   assign crc_base = (item_ff.command == mbrf_pkg::CMD_HEADER && idx_ff == 4'd0)
                   ? mbrf_pkg::CRC_INIT : crc_ff;

   // pick the byte for the current position of the current item
   always_comb begin
      byte_val  = 8'h00;
      is_crc    = 1'b0;
      last      = 1'b0;
      frame_end = 1'b0;
      drop      = 1'b0;
      if (item_ff.command == mbrf_pkg::CMD_HEADER) begin
         unique case (idx_ff)
            4'd0: byte_val = item_ff.slave_address;
            4'd1: byte_val = item_ff.function_code;
            4'd2: byte_val = item_ff.start_address[15:8];
            4'd3: byte_val = item_ff.start_address[7:0];
            4'd4: byte_val = item_ff.quantity[15:8];
            4'd5: begin
               byte_val  = item_ff.quantity[7:0];
               last      = !is_read && !is_write;
               frame_end = !is_read && !is_write;
            end
            4'd6: begin
               if (is_read) begin
                  byte_val = crc_ff[7:0];
                  is_crc   = 1'b1;
               end else begin
                  byte_val = item_ff.data_len;
                  last     = (item_ff.data_len != 8'd0);
               end
            end
            4'd7: begin
               is_crc = 1'b1;
               if (is_read) begin
                  byte_val  = crc_ff[15:8];
                  last      = 1'b1;
                  frame_end = 1'b1;
               end else begin
                  byte_val = crc_ff[7:0];
               end
            end
            4'd8: begin
               byte_val  = crc_ff[15:8];
               is_crc    = 1'b1;
               last      = 1'b1;
               frame_end = 1'b1;
            end
            default: last = 1'b1;
         endcase
      end else if (!wframe_ff) begin
         drop = 1'b1;
         last = 1'b1;
      end else begin
         unique case (idx_ff)
            4'd0: byte_val = item_ff.data_word[15:8];
            4'd1: begin
               byte_val = item_ff.data_word[7:0];
               last     = !item_ff.final_word;
            end
            4'd2: begin
               byte_val = crc_ff[7:0];
               is_crc   = 1'b1;
            end
            4'd3: begin
               byte_val  = crc_ff[15:8];
               is_crc    = 1'b1;
               last      = 1'b1;
               frame_end = 1'b1;
            end
            default: last = 1'b1;
         endcase
      end
   end

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign step      = busy_ff && (drop || slot_free);
   assign req_ready = !busy_ff || (step && last);
   assign accept    = req.valid && req_ready;

   always_comb begin
      item_in      = item_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      wframe_in    = wframe_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;

      if (step && !drop) begin
         if (frame_end) begin
            crc_in    = mbrf_pkg::CRC_INIT;
            wframe_in = 1'b0;
         end else begin
            if (!is_crc) begin
               crc_in = mbrf_pkg::crc_byte(crc_base, byte_val);
            end
            // header of a write multiple leaves the frame open for data words
            if (last && item_ff.command == mbrf_pkg::CMD_HEADER) begin
               wframe_in = 1'b1;
            end
         end
      end

      if (slot_free) begin
         rsp_valid_in = step && !drop;
         rsp_byte_in  = byte_val;
         rsp_end_in   = frame_end;
      end

      if (accept) begin
         item_in = req_item;
         busy_in = 1'b1;
         idx_in  = 4'd0;
      end else if (step && last) begin
         busy_in = 1'b0;
      end else if (step) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 4'd0;
         crc_ff       <= mbrf_pkg::CRC_INIT;
         wframe_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         wframe_ff    <= wframe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign req.ready      = req_ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.frame_byte = rsp_byte_ff;
   assign rsp.frame_end  = rsp_end_ff;

endmodule

@@ hdl/mbrf_checker.sv @@
// Port-level checks for the Modbus RTU request framer, bound to the top level.
// Depends on mbrf_pkg and modbus_rtu_request_framer_defines.svh.
`include "modbus_rtu_request_framer_defines.svh"

module mbrf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_command,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_frame_end
);

   logic hdr_transfer;

   assign hdr_transfer = req_valid && req_ready && (req_command == mbrf_pkg::CMD_HEADER);

   // output register starts empty
   `MBRF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // stalled byte holds
   `MBRF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_frame_end), "stalled frame byte changed")

   // a header always yields a first byte as soon as the output slot frees
   `MBRF_ASSERT(a_hdr_starts, clock, reset, hdr_transfer ##1 (rsp_ready || !rsp_valid) |=> rsp_valid, "header transfer produced no byte")

endmodule

bind modbus_rtu_request_framer mbrf_checker u_mbrf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_command    (req.command),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_frame_byte (rsp.frame_byte),
   .rsp_frame_end  (rsp.frame_end)
);

@@ tb/sv/modbus_rtu_request_framer_tb.sv @@
// Self-checking testbench for modbus_rtu_request_framer: header and data word requests in,
// checked frame bytes with CRC-16/MODBUS out. Depends on mbrf_pkg and the mbrf_req_if /
// mbrf_rsp_if channel interfaces.
module modbus_rtu_request_framer_tb;

   localparam int PREDICT       = -1;   // row is checked against the frame predictor
   localparam int RANDOM_ITEMS  = 220;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } frame_out_type;

   typedef struct packed {
      mbrf_pkg::req_item_type item;
      int                     golden_n;
      logic [71:0]            golden;   // bytes left aligned; frame_end on the last one
   } directed_row_type;

   logic clock;
   logic reset;

   mbrf_req_if req_bus ();
   mbrf_rsp_if rsp_bus ();

   modbus_rtu_request_framer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // frame predictor state
   logic [15:0] crc_acc;
   logic        write_open;

   frame_out_type    predicted_bytes [$];
   frame_out_type    expected_bytes [$];
   directed_row_type directed_table [$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int items_sent;
   int productive_items;
   int bytes_checked;
   int frames_seen;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      // bit-serial form of the reflected update, LSB of the data first
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r  = {1'b0, r[15:1]} ^ (fb ? mbrf_pkg::CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic frame_out_type pack_out(input logic [7:0] b, input logic e);
      frame_out_type r;
      r.frame_byte = b;
      r.frame_end  = e;
      return r;
   endfunction

   function automatic void add_row(input mbrf_pkg::req_item_type it, input int golden_n,
                                   input logic [71:0] golden);
      directed_row_type row;
      row.item     = it;
      row.golden_n = golden_n;
      row.golden   = golden;
      directed_table.insert(directed_table.size(), row);
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input logic last);
      predicted_bytes.insert(predicted_bytes.size(), pack_out(b, last));
      crc_acc = crc16_fold(crc_acc, b);
   endfunction

   function automatic void emit_crc();
      logic [15:0] c;
      c = crc_acc;
      predicted_bytes.insert(predicted_bytes.size(), pack_out(c[7:0], 1'b0));
      predicted_bytes.insert(predicted_bytes.size(), pack_out(c[15:8], 1'b1));
      crc_acc    = mbrf_pkg::CRC_INIT;
      write_open = 1'b0;
   endfunction

   function automatic void predict_frame(input mbrf_pkg::req_item_type it);
      logic is_read;
      logic is_write;
      predicted_bytes.delete();
      if (it.command == mbrf_pkg::CMD_HEADER) begin
         is_read  = (it.function_code == mbrf_pkg::FC_READ_COILS) ||
                    (it.function_code == mbrf_pkg::FC_READ_INPUTS) ||
                    (it.function_code == mbrf_pkg::FC_READ_HOLDING);
         is_write = (it.function_code == mbrf_pkg::FC_WRITE_MULTIPLE);
         // a header always restarts the frame, dropping any open write
         crc_acc    = mbrf_pkg::CRC_INIT;
         write_open = 1'b0;
         emit_byte(it.slave_address, 1'b0);
         emit_byte(it.function_code, 1'b0);
         emit_byte(it.start_address[15:8], 1'b0);
         emit_byte(it.start_address[7:0], 1'b0);
         emit_byte(it.quantity[15:8], 1'b0);
         emit_byte(it.quantity[7:0], !is_read && !is_write);
         if (is_read) begin
            emit_crc();
         end else if (is_write) begin
            emit_byte(it.data_len, 1'b0);
            if (it.data_len == 8'h00) begin
               emit_crc();
            end else begin
               write_open = 1'b1;
            end
         end else begin
            crc_acc = mbrf_pkg::CRC_INIT;
         end
      end else if (write_open) begin
         emit_byte(it.data_word[15:8], 1'b0);
         emit_byte(it.data_word[7:0], 1'b0);
         if (it.final_word) begin
            emit_crc();
         end
      end
   endfunction

   function automatic mbrf_pkg::req_item_type make_header(input logic [7:0] addr,
                                                          input logic [7:0] fc,
                                                          input logic [15:0] start,
                                                          input logic [15:0] qty,
                                                          input logic [7:0] count);
      // data fields carry a pattern the block must ignore
      return '{mbrf_pkg::CMD_HEADER, addr, fc, start, qty, count, 16'hA5A5, 1'b1};
   endfunction

   function automatic mbrf_pkg::req_item_type make_word(input logic [15:0] word,
                                                        input logic last);
      return '{mbrf_pkg::CMD_DATA, 8'hC3, mbrf_pkg::FC_READ_HOLDING, 16'h3C3C, 16'hF00F,
               8'h00, word, last};
   endfunction

   function automatic mbrf_pkg::req_item_type random_item();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[73:0];
   endfunction

   task automatic send_item(input mbrf_pkg::req_item_type it, input int golden_n,
                            input logic [71:0] golden);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      {req_bus.command, req_bus.slave_address, req_bus.function_code, req_bus.start_address,
       req_bus.quantity, req_bus.data_len, req_bus.data_word, req_bus.final_word} = it;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      // transfer taken at this edge: predict before any of its bytes can appear
      predict_frame(it);
      if (golden_n == PREDICT) begin
         foreach (predicted_bytes[k]) begin
            expected_bytes.insert(expected_bytes.size(), predicted_bytes[k]);
         end
      end else begin
         for (int k = 0; k < golden_n; k++) begin
            expected_bytes.insert(expected_bytes.size(),
                                  pack_out(golden[71 - 8*k -: 8], k == golden_n - 1));
         end
      end
      items_sent++;
      if (predicted_bytes.size() != 0) productive_items++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
   endtask

   // result channel: random backpressure, compare each transfer with the oldest expectation
   initial begin : result_monitor
      frame_out_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            bytes_checked++;
            if (rsp_bus.frame_end) frames_seen++;
            if (expected_bytes.size() == 0) begin
               error_count++;
               $display("[%0t] unexpected frame byte %02h (end %0b), nothing expected",
                        $time, rsp_bus.frame_byte, rsp_bus.frame_end);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_bus.frame_byte !== want.frame_byte) begin
                  error_count++;
                  $display("[%0t] frame_byte mismatch: expected %02h, actual %02h",
                           $time, want.frame_byte, rsp_bus.frame_byte);
               end
               if (rsp_bus.frame_end !== want.frame_end) begin
                  error_count++;
                  $display("[%0t] frame_end mismatch: expected %0b, actual %0b",
                           $time, want.frame_end, rsp_bus.frame_end);
               end
            end
         end
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d bytes still expected",
               $time, QUIET_LIMIT, expected_bytes.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      mbrf_pkg::req_item_type it;
      mbrf_pkg::req_item_type word;
      int                     kind;
      int                     n_words;
      int                     phase;
      int                     cur_phase;
      logic                   abandon;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      {req_bus.command, req_bus.slave_address, req_bus.function_code, req_bus.start_address,
       req_bus.quantity, req_bus.data_len, req_bus.data_word, req_bus.final_word} = '0;
      crc_acc          = mbrf_pkg::CRC_INIT;
      write_open       = 1'b0;
      send_idle_pct    = 15;
      recv_idle_pct    = 85;
      error_count      = 0;
      items_sent       = 0;
      productive_items = 0;
      bytes_checked    = 0;
      frames_seen      = 0;

      // data word right after reset: no frame open, dropped
      add_row(make_word(16'hFFFF, 1'b1), 0, 72'h0);
      // unknown function codes: six plain bytes
      add_row(make_header(8'hFF, 8'h00, 16'hFFFF, 16'h0000, 8'h00),
              6, {48'hFF00_FFFF_0000, 24'h0});
      add_row(make_header(8'h00, 8'hFF, 16'h0000, 16'hFFFF, 8'hFF),
              6, {48'h00FF_0000_FFFF, 24'h0});
      add_row(make_header(8'h01, mbrf_pkg::FC_READ_HOLDING, 16'h0000, 16'h0001, 8'h00),
              8, {64'h0103_0000_0001_840A, 8'h0});
      add_row(make_header(8'hFF, mbrf_pkg::FC_READ_COILS, 16'hFFFF, 16'hFFFF, 8'hFF),
              PREDICT, 72'h0);
      add_row(make_header(8'h00, mbrf_pkg::FC_READ_INPUTS, 16'h0000, 16'h0000, 8'h00),
              PREDICT, 72'h0);
      // write multiple with a zero byte count closes at once
      add_row(make_header(8'h11, mbrf_pkg::FC_WRITE_MULTIPLE, 16'h0001, 16'h0000, 8'h00),
              PREDICT, 72'h0);
      add_row(make_header(8'h11, mbrf_pkg::FC_WRITE_MULTIPLE, 16'h0001, 16'h0002, 8'h04),
              PREDICT, 72'h0);
      add_row(make_word(16'hFFFF, 1'b0), PREDICT, 72'h0);
      add_row(make_word(16'h0000, 1'b1), PREDICT, 72'h0);
      // frame closed: a further word is dropped
      add_row(make_word(16'h1234, 1'b1), 0, 72'h0);
      // open write abandoned by a read header
      add_row(make_header(8'hFE, mbrf_pkg::FC_WRITE_MULTIPLE, 16'h1000, 16'h0001, 8'hFF),
              PREDICT, 72'h0);
      add_row(make_word(16'hABCD, 1'b0), PREDICT, 72'h0);
      add_row(make_header(8'h01, mbrf_pkg::FC_READ_HOLDING, 16'h006B, 16'h0003, 8'h00),
              PREDICT, 72'h0);
      add_row(make_word(16'h5555, 1'b1), 0, 72'h0);
      // more words than the byte count announces
      add_row(make_header(8'h7F, mbrf_pkg::FC_WRITE_MULTIPLE, 16'h0000, 16'h0001, 8'h02),
              PREDICT, 72'h0);
      add_row(make_word(16'h00FF, 1'b0), PREDICT, 72'h0);
      add_row(make_word(16'hFF00, 1'b0), PREDICT, 72'h0);
      add_row(make_word(16'h8001, 1'b1), PREDICT, 72'h0);
      // open write abandoned by an unknown function code
      add_row(make_header(8'h22, mbrf_pkg::FC_WRITE_MULTIPLE, 16'h0003, 16'h0002, 8'h04),
              PREDICT, 72'h0);
      add_row(make_word(16'h0F0F, 1'b0), PREDICT, 72'h0);
      add_row(make_header(8'h22, 8'h04, 16'h0102, 16'h0304, 8'h00),
              6, {48'h2204_0102_0304, 24'h0});
      add_row(make_header(8'h33, 8'h0F, 16'h8000, 16'h7FFF, 8'h80), PREDICT, 72'h0);
      add_row(make_header(8'h80, mbrf_pkg::FC_WRITE_MULTIPLE, 16'h7FFF, 16'h8000, 8'h01),
              PREDICT, 72'h0);
      add_row(make_word(16'h7FFE, 1'b1), PREDICT, 72'h0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_table[r]) begin
         send_item(directed_table[r].item, directed_table[r].golden_n, directed_table[r].golden);
      end
      // hold off until the directed frames are out
      drain_results();

      productive_items = 0;
      cur_phase        = 0;
      while (productive_items < RANDOM_ITEMS) begin
         phase = productive_items * 3 / RANDOM_ITEMS;
         if (phase != cur_phase) begin
            drain_results();
            cur_phase = phase;
            if (phase == 1) begin
               send_idle_pct = 85;
               recv_idle_pct = 15;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         end

         it   = random_item();
         kind = $urandom_range(99);
         if (kind < 35) begin
            it.command = mbrf_pkg::CMD_HEADER;
            case ($urandom_range(2))
               0: it.function_code = mbrf_pkg::FC_READ_COILS;
               1: it.function_code = mbrf_pkg::FC_READ_INPUTS;
               default: it.function_code = mbrf_pkg::FC_READ_HOLDING;
            endcase
            send_item(it, PREDICT, 72'h0);
         end else if (kind < 72) begin
            it.command       = mbrf_pkg::CMD_HEADER;
            it.function_code = mbrf_pkg::FC_WRITE_MULTIPLE;
            if ($urandom_range(9) == 0) it.data_len = 8'h00;
            send_item(it, PREDICT, 72'h0);
            if (it.data_len != 8'h00) begin
               n_words = $urandom_range(1, 4);
               abandon = ($urandom_range(9) == 0);
               for (int w = 0; w < n_words; w++) begin
                  word            = random_item();
                  word.command    = mbrf_pkg::CMD_DATA;
                  word.final_word = (w == n_words - 1) && !abandon;
                  send_item(word, PREDICT, 72'h0);
               end
            end
         end else if (kind < 86) begin
            // any function code, mostly unknown ones
            it.command = mbrf_pkg::CMD_HEADER;
            send_item(it, PREDICT, 72'h0);
         end else begin
            // stray word: dropped unless a write happens to be open
            it.command = mbrf_pkg::CMD_DATA;
            send_item(it, PREDICT, 72'h0);
         end

         if ($urandom_range(99) < 3) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request items and checked %0d frame bytes closing %0d frames,",
               items_sent, bytes_checked, frames_seen);
      $display("under sender-heavy, receiver-heavy and stall-free backpressure.");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
